// ===== sv/assert_macros.svh =====
// Assertion macros used by the segmenter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("implication check failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== sv/tfs_pkg.sv =====
// Types and constants of the transport frame segmenter.
package tfs_pkg;

  localparam int unsigned IdW    = 11;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned FrameW = 64;
  localparam int unsigned FlenW  = 4;
  localparam int unsigned FillW  = 3;
  localparam int unsigned SeqW   = 4;
  localparam int unsigned StoreLanes = 7;

  localparam logic [ByteW-1:0] FIRST_FRAME_PCI  = 8'h10;
  localparam logic [ByteW-1:0] CONSEC_FRAME_PCI = 8'h20;
  localparam logic [ByteW-1:0] FIRST_CONSEC_PCI = 8'h21;
  localparam logic [SeqW-1:0]  SeqReset         = FIRST_CONSEC_PCI[SeqW-1:0];

  localparam logic [ByteW-1:0] SingleLimit = 8'd7;
  localparam logic [ByteW-1:0] FfDataBytes = 8'd6;
  localparam logic [FlenW-1:0] FfFillBytes = 4'd6;
  localparam logic [FlenW-1:0] CfFillBytes = 4'd7;
  localparam logic [FlenW-1:0] MaxFrameLen = 4'd8;

  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [FrameW-1:0] bytes;
    logic [FlenW-1:0]  length;
    logic              last;
  } frame_t;

  typedef struct packed {
    logic main_valid;
    logic skid_valid;
  } buf_status_t;

endpackage

// ===== sv/tfs_intf.sv =====
// Handshake interfaces for the input, result and configuration channels.
interface tfs_in_if;
  import tfs_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] payload_byte;
  logic [ByteW-1:0] message_length;
  modport source (output valid, payload_byte, message_length, input ready);
  modport sink (input valid, payload_byte, message_length, output ready);
endinterface

interface tfs_out_if;
  import tfs_pkg::*;
  logic              valid;
  logic              ready;
  logic [IdW-1:0]    frame_id;
  logic [FrameW-1:0] frame_bytes;
  logic [FlenW-1:0]  frame_length;
  logic              last_frame;
  modport source (output valid, frame_id, frame_bytes, frame_length, last_frame,
                  input ready);
  modport sink (input valid, frame_id, frame_bytes, frame_length, last_frame,
                output ready);
endinterface

interface tfs_cfg_if;
  import tfs_pkg::*;
  logic           valid;
  logic           ready;
  logic [IdW-1:0] target_id;
  modport source (output valid, target_id, input ready);
  modport sink (input valid, target_id, output ready);
endinterface

// ===== sv/tfs_core.sv =====
// Segmentation state and per-byte frame assembly.
module tfs_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic [tfs_pkg::ByteW-1:0] payload_byte_i,
  input  logic [tfs_pkg::ByteW-1:0] message_length_i,
  input  logic [tfs_pkg::IdW-1:0]   target_id_i,
  output logic                      res_valid_o,
  output tfs_pkg::frame_t           res_o
);
  import tfs_pkg::*;

  logic [ByteW-1:0]                  bytes_taken_q;
  logic [StoreLanes-1:0][ByteW-1:0]  store_q, store_ins;
  logic [FillW-1:0]                  fill_q;
  logic [SeqW-1:0]                   seq_q;

  logic [ByteW-1:0] count;
  logic             ends;
  logic [FlenW-1:0] n, n_p1, flen_var;
  logic             is_single, use_ff, use_cf, emit;

  always_comb begin
    for (int k = 0; k < StoreLanes; k++) begin
      store_ins[k] = store_q[k] | ((fill_q == FillW'(k)) ? payload_byte_i : '0);
    end
  end

  assign count     = bytes_taken_q + 8'd1;
  assign ends      = (count >= message_length_i) || (count == '0);
  assign n         = {1'b0, fill_q} + 4'd1;
  assign n_p1      = n + 4'd1;
  assign flen_var  = (n_p1 > MaxFrameLen) ? MaxFrameLen : n_p1;
  assign is_single = message_length_i < SingleLimit;
  assign use_ff    = !is_single && (bytes_taken_q < FfDataBytes) && (n >= FfFillBytes);
  assign use_cf    = !is_single && (bytes_taken_q >= FfDataBytes)
                     && ((n >= CfFillBytes) || ends);
  assign emit      = ends || use_ff || use_cf;

  assign res_valid_o = accept_i && emit;

  always_comb begin
    res_o.id   = target_id_i;
    res_o.last = ends;
    if (use_ff) begin
      res_o.bytes  = {store_ins[5:0], message_length_i, FIRST_FRAME_PCI};
      res_o.length = MaxFrameLen;
    end else if (use_cf) begin
      res_o.bytes  = {store_ins, CONSEC_FRAME_PCI | {4'b0, seq_q}};
      res_o.length = flen_var;
    end else begin
      // Single frame, also used when a message ends without any other frame.
      res_o.bytes  = {store_ins, 4'b0, n};
      res_o.length = flen_var;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_taken_q <= '0;
      store_q       <= '0;
      fill_q        <= '0;
      seq_q         <= SeqReset;
    end else if (accept_i) begin
      if (ends) begin
        bytes_taken_q <= '0;
        store_q       <= '0;
        fill_q        <= '0;
        seq_q         <= SeqReset;
      end else begin
        bytes_taken_q <= count;
        if (emit) begin
          store_q <= '0;
          fill_q  <= '0;
        end else begin
          store_q <= store_ins;
          fill_q  <= n[FillW-1:0];
        end
        if (use_cf) begin
          seq_q <= seq_q + 4'd1;
        end
      end
    end
  end

endmodule

// ===== sv/tfs_out_buf.sv =====
// Two-slot result register: output stage plus skid slot.
module tfs_out_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  tfs_pkg::frame_t      data_i,
  output tfs_pkg::buf_status_t status_o,
  tfs_out_if.source            out_o
);
  import tfs_pkg::*;

  logic   main_valid_q, skid_valid_q;
  frame_t main_q, skid_q;
  logic   pop;

  assign pop = main_valid_q && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        main_valid_q <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (push_i) begin
      if (!main_valid_q || pop) begin
        main_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (pop) begin
      main_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        main_q <= skid_q;
      end
    end else if (push_i) begin
      if (!main_valid_q || pop) begin
        main_q <= data_i;
      end else begin
        skid_q <= data_i;
      end
    end
  end

  assign out_o.valid        = main_valid_q;
  assign out_o.frame_id     = main_q.id;
  assign out_o.frame_bytes  = main_q.bytes;
  assign out_o.frame_length = main_q.length;
  assign out_o.last_frame   = main_q.last;

  assign status_o.main_valid = main_valid_q;
  assign status_o.skid_valid = skid_valid_q;

endmodule

// ===== sv/transport_frame_segmenter.sv =====
// Transport frame segmenter: splits a byte stream into CAN-style transport frames.
// Throughput is one payload item per cycle while the skid slot is free; the segmentation state updates on accept.
// A frame is registered on the edge that accepts its completing byte, into the output
// stage or, if that holds a frame not taken, the skid slot. A skid slot keeps input open while a
// finished frame waits. Reset clears the message state, the target id and the buffer.
`include "assert_macros.svh"

module transport_frame_segmenter (
  input  logic        clk_i,
  input  logic        rst_ni,
  tfs_in_if.sink      in_i,
  tfs_cfg_if.sink     cfg_i,
  tfs_out_if.source   out_o
);
  import tfs_pkg::*;

  // Identifier placed on every frame. The user must write it only while the block is idle; nothing enforces it.
  logic [IdW-1:0] target_id_q;

  logic        accept;
  logic        res_valid;
  frame_t      res;
  buf_status_t buf_status;

  // Configuration is always taken.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_id_q <= '0;
    end else if (cfg_i.valid) begin
      target_id_q <= cfg_i.target_id;
    end
  end

  // Input is open as long as the skid slot is free, so a byte can enter
  // even while the output stage holds a frame that has not been taken.
  assign in_i.ready = !buf_status.skid_valid;
  assign accept     = in_i.valid && in_i.ready;

  // Per-byte assembly: the state registers and the frame builder.
  tfs_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .payload_byte_i  (in_i.payload_byte),
    .message_length_i(in_i.message_length),
    .target_id_i     (target_id_q),
    .res_valid_o     (res_valid),
    .res_o           (res)
  );

  // Result register with a skid slot behind it.
  tfs_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res),
    .status_o(buf_status),
    .out_o   (out_o)
  );

  // The skid slot only fills behind an occupied output stage.
  `ASSERT_IMPLY(a_skid_behind_main, clk_i, rst_ni, buf_status.skid_valid, buf_status.main_valid)
  // A frame that does not end the message is always a full eight bytes.
  `ASSERT_IMPLY(a_mid_frame_full, clk_i, rst_ni, res_valid && !res.last, res.length == MaxFrameLen)
  // Every frame carries a header byte and at least one payload byte.
  `ASSERT_IMPLY(a_frame_len_range, clk_i, rst_ni, res_valid, res.length >= 4'd2 && res.length <= MaxFrameLen)
  // A waiting skid entry keeps the output stage valid in the next cycle.
  `ASSERT_NEXT(a_skid_drains, clk_i, rst_ni, buf_status.skid_valid, buf_status.main_valid)

endmodule

// ===== tb/sv/tb_transport_frame_segmenter.sv =====
// Self-checking testbench of the transport frame segmenter, driving all three channels.
`timescale 1ns / 100ps

module tb_transport_frame_segmenter;
  import tfs_pkg::*;

  // The watchdog ends the run after this many cycles with no handshake on any channel.
  // The longest quiet stretch is the receiver hold below plus a few drawn gaps.
  localparam int unsigned WatchdogLimit = 1000;
  // Cycles that the receiver holds ready low once, while the sender keeps offering.
  localparam int unsigned LongHold      = 200;
  // The block registers a frame on the edge that accepts the byte that completes it, and a
  // skid slot may hold a second one. The settle wait covers any frame still in flight.
  localparam int unsigned SettleCycles  = 4;
  localparam int unsigned DrainCycles   = 16;
  localparam int unsigned PhaseItems    = 140;
  localparam int unsigned NumPhases     = 6;
  localparam int unsigned NumRows       = 19;

  // One row of the directed table. Where check is set, want is the frame that the row
  // must cause, typed in by hand; other rows are checked against the predictor.
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic [ByteW-1:0] len;
    logic             check;
    frame_t           want;
  } stim_row_t;

  // Per accepted item: a hand-typed expectation, if the row carries one.
  typedef struct packed {
    logic   check;
    frame_t want;
  } row_check_t;

  // The directed part runs right after reset, so every typed frame carries id zero.
  localparam stim_row_t StimRows [NumRows] = '{
    // Shortest message: one byte, single frame with length byte 1.
    '{8'hAB, 8'd1, 1'b1, '{11'd0, 64'h0000_0000_0000_AB01, 4'd2, 1'b1}},
    // Zero length ends the message on the byte that carries it.
    '{8'hFF, 8'd0, 1'b1, '{11'd0, 64'h0000_0000_0000_FF01, 4'd2, 1'b1}},
    // Longest single frame: six bytes, both byte extremes among them.
    '{8'h00, 8'd6, 1'b0, '0},
    '{8'hFF, 8'd6, 1'b0, '0},
    '{8'h01, 8'd6, 1'b0, '0},
    '{8'h80, 8'd6, 1'b0, '0},
    '{8'h7F, 8'd6, 1'b0, '0},
    '{8'h55, 8'd6, 1'b1, '{11'd0, 64'h0055_7F80_01FF_0006, 4'd7, 1'b1}},
    // Shortest segmented message: a first frame, then one consecutive frame.
    '{8'h11, 8'd7, 1'b0, '0},
    '{8'h12, 8'd7, 1'b0, '0},
    '{8'h13, 8'd7, 1'b0, '0},
    '{8'h14, 8'd7, 1'b0, '0},
    '{8'h15, 8'd7, 1'b0, '0},
    '{8'h16, 8'd7, 1'b1, '{11'd0, 64'h1615_1413_1211_0710, 4'd8, 1'b0}},
    '{8'h17, 8'd7, 1'b1, '{11'd0, 64'h0000_0000_0000_1721, 4'd2, 1'b1}},
    // The length changes mid-message, from the maximum down to a short one.
    '{8'hA0, 8'd255, 1'b0, '0},
    '{8'hA1, 8'd255, 1'b0, '0},
    '{8'hA2, 8'd255, 1'b0, '0},
    '{8'hA3, 8'd2,   1'b0, '0}
  };

  logic clk;
  logic rst_n;

  tfs_in_if  in_if ();
  tfs_out_if out_if ();
  tfs_cfg_if cfg_if ();

  transport_frame_segmenter dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  // Predictor state: the message being segmented and the configured identifier.
  logic [ByteW-1:0] msg_taken = '0;
  logic [63:0]      msg_store = '0;
  logic [FillW-1:0] msg_fill  = '0;
  logic [SeqW-1:0]  cf_seq    = SeqReset;
  logic [IdW-1:0]   target_q  = '0;

  frame_t     frames_due [$];
  row_check_t row_checks [$];
  int unsigned fail_count = 0;

  // Idle behavior of each side: 0 never waits, 1 waits a drawn gap before every item,
  // 2 mostly streams with an occasional drawn gap.
  int unsigned src_mode  = 1;
  int unsigned sink_mode = 1;
  bit          hold_sink = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Segments one accepted byte. Returns 1 and fills frame when the byte completes a
  // frame. Every decision uses the length that comes with this very byte.
  function automatic bit segment_byte(input logic [ByteW-1:0] data,
                                      input logic [ByteW-1:0] len, output frame_t frame);
    logic [ByteW-1:0] count;
    logic             ends;
    logic             emit;
    logic             last;
    logic [FlenW-1:0] held;
    logic [63:0]      bytes;
    logic [FlenW-1:0] flen;
    count = msg_taken + 8'd1;
    // A count that wraps to zero also closes the message.
    ends  = (count >= len) || (count == 8'd0);
    emit  = 1'b0;
    last  = 1'b0;
    bytes = '0;
    flen  = '0;
    if (msg_fill < 3'd7) begin
      msg_store = msg_store | (64'(data) << (8 * msg_fill));
    end
    held = {1'b0, msg_fill} + 4'd1;

    if (len < SingleLimit) begin
      // Short message: only its end produces a frame, the single frame.
      if (ends) begin
        emit  = 1'b1;
        last  = 1'b1;
        bytes = (msg_store << 8) | 64'(held);
        flen  = held + 4'd1;
      end
    end else if (msg_taken < FfDataBytes) begin
      // First frame: protocol byte, then the length, then six payload bytes.
      if (held >= FfFillBytes) begin
        emit  = 1'b1;
        last  = ends;
        bytes = (msg_store << 16) | (64'(len) << 8) | 64'(FIRST_FRAME_PCI);
        flen  = MaxFrameLen;
      end
    end else if (held >= CfFillBytes || ends) begin
      // Consecutive frame: sequence number in the low nibble, wrapping mod 16.
      emit   = 1'b1;
      last   = ends;
      bytes  = (msg_store << 8) | 64'(CONSEC_FRAME_PCI | {4'h0, cf_seq});
      flen   = held + 4'd1;
      cf_seq = cf_seq + 4'd1;
    end

    if (ends) begin
      // A message that ends inside a first frame still leaves as a single frame.
      if (!emit) begin
        emit  = 1'b1;
        last  = 1'b1;
        bytes = (msg_store << 8) | 64'(held);
        flen  = held + 4'd1;
      end
      msg_taken = '0;
      msg_store = '0;
      msg_fill  = '0;
      cf_seq    = SeqReset;
    end else begin
      msg_taken = count;
      if (emit) begin
        msg_store = '0;
        msg_fill  = '0;
      end else begin
        msg_fill = held[FillW-1:0];
      end
    end

    if (flen > MaxFrameLen) begin
      flen = MaxFrameLen;
    end
    frame = '{target_q, bytes, flen, last};
    return emit;
  endfunction

  function automatic int unsigned draw_gap(input int unsigned mode);
    case (mode)
      0: return 0;
      1: return $urandom_range(0, 14);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
    endcase
  endfunction

  task automatic log_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%s", msg);
    end
  endtask

  // Predicts on every accepted byte, then checks every accepted frame against the
  // oldest expectation. Prediction comes first so that ordering within the edge does
  // not matter even for a frame that left on the same edge.
  always @(posedge clk) begin : check_frames
    frame_t     want;
    frame_t     got;
    row_check_t row;
    bit         emit;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        emit = segment_byte(in_if.payload_byte, in_if.message_length, want);
        row  = (row_checks.size() != 0) ? row_checks.pop_front() : '0;
        if (row.check) begin
          frames_due = {frames_due, row.want};
        end else if (emit) begin
          frames_due = {frames_due, want};
        end
      end
      if (cfg_if.valid && cfg_if.ready) begin
        target_q = cfg_if.target_id;
      end
      if (out_if.valid && out_if.ready) begin
        got = {out_if.frame_id, out_if.frame_bytes, out_if.frame_length, out_if.last_frame};
        if (frames_due.size() == 0) begin
          log_failure($sformatf("unexpected frame: id=%h bytes=%h len=%0d last=%b",
                                got.id, got.bytes, got.length, got.last));
        end else begin
          want = frames_due.pop_front();
          if (got.id !== want.id || got.bytes !== want.bytes ||
              got.length !== want.length || got.last !== want.last) begin
            log_failure($sformatf({"frame mismatch: expected id=%h bytes=%h len=%0d ",
                                   "last=%b, got id=%h bytes=%h len=%0d last=%b"},
                                  want.id, want.bytes, want.length, want.last,
                                  got.id, got.bytes, got.length, got.last));
          end
        end
      end
    end
  end

  // Receiver: waits a drawn number of cycles before taking each frame. Once, on
  // request, it holds ready low for a long stretch so that the block backs up.
  initial begin : frame_receiver
    int unsigned gap;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_sink) begin
        out_if.ready <= 1'b0;
        repeat (LongHold) @(negedge clk);
        hold_sink = 1'b0;
      end
      gap = draw_gap(sink_mode);
      if (gap != 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
    end
  end

  // Ends the run when no channel has moved an item for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_n);
    while (quiet < WatchdogLimit) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("transport_frame_segmenter test failed");
    $finish;
  end

  // Offers one byte after a drawn gap and returns once it is accepted. Valid stays
  // high into the next item when the gap is zero.
  task automatic send_item(input logic [ByteW-1:0] data, input logic [ByteW-1:0] len,
                           input logic check = 1'b0, input frame_t want = '0);
    int unsigned gap;
    row_check_t  entry;
    gap = draw_gap(src_mode);
    @(negedge clk);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    entry      = '{check, want};
    row_checks = {row_checks, entry};
    in_if.valid          <= 1'b1;
    in_if.payload_byte   <= data;
    in_if.message_length <= len;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic write_target(input logic [IdW-1:0] id);
    @(negedge clk);
    cfg_if.valid     <= 1'b1;
    cfg_if.target_id <= id;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Closes a phase: an open message is ended with a byte of length one, which always
  // completes it, and the sender then waits until every frame has come out.
  task automatic finish_phase();
    @(negedge clk);
    in_if.valid <= 1'b0;
    if (msg_taken != 0) begin
      send_item(8'($urandom), 8'd1);
      @(negedge clk);
      in_if.valid <= 1'b0;
    end
    while (frames_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Lengths lean toward short and mid-size messages; a few run to the maximum so
  // that the sequence number wraps.
  function automatic logic [ByteW-1:0] pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) return 8'($urandom_range(1, 6));
    if (r < 45) return 8'($urandom_range(7, 13));
    if (r < 80) return 8'($urandom_range(14, 60));
    if (r < 95) return 8'($urandom_range(61, 200));
    return 8'd255;
  endfunction

  // Mostly whole messages with random payload; the rest are cut short, change their
  // length on the way, or carry a zero length. The last message of a phase is cut
  // at the budget and closed by the phase end.
  task automatic send_messages(input int unsigned budget, input bit start_max);
    int unsigned sent;
    int unsigned kind;
    int unsigned count;
    logic [ByteW-1:0] len;
    sent = 0;
    while (sent < budget) begin
      len   = (start_max && sent == 0) ? 8'd255 : pick_length();
      kind  = $urandom_range(0, 99);
      count = (kind < 85) ? len : $urandom_range(1, len);
      if (count > budget - sent) begin
        count = budget - sent;
      end
      for (int unsigned i = 0; i < count; i++) begin
        if (kind >= 97) begin
          send_item(8'($urandom), 8'd0);
        end else if (kind >= 91 && $urandom_range(0, 2) == 0) begin
          send_item(8'($urandom), 8'($urandom_range(0, 255)));
        end else begin
          send_item(8'($urandom), len);
        end
      end
      sent += count;
    end
  endtask

  initial begin : stimulus
    logic [IdW-1:0] phase_ids [NumPhases];
    in_if.valid          = 1'b0;
    in_if.payload_byte   = '0;
    in_if.message_length = '0;
    cfg_if.valid         = 1'b0;
    cfg_if.target_id     = '0;
    clk                  = 1'b0;
    rst_n                = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table, with the identifier still at its reset value.
    for (int unsigned r = 0; r < NumRows; r++) begin
      send_item(StimRows[r].data, StimRows[r].len, StimRows[r].check, StimRows[r].want);
    end
    finish_phase();

    // Random phases, each under its own identifier; the first two are the extremes
    // and the alternating patterns flip every bit of the register.
    phase_ids[0] = 11'h7FF;
    phase_ids[1] = 11'h000;
    phase_ids[2] = 11'($urandom);
    phase_ids[3] = 11'h555;
    phase_ids[4] = 11'h2AA;
    phase_ids[5] = 11'($urandom);
    for (int unsigned p = 0; p < NumPhases; p++) begin
      write_target(phase_ids[p]);
      src_mode  = p % 3;
      sink_mode = (p + 1) % 3;
      // In one phase the receiver stalls long enough for the input to back up.
      if (p == 2) begin
        hold_sink = 1'b1;
      end
      send_messages(PhaseItems, p == 0);
      finish_phase();
    end

    repeat (DrainCycles) @(posedge clk);
    if (frames_due.size() != 0) begin
      log_failure($sformatf("%0d expected frames never arrived", frames_due.size()));
    end
    if (fail_count == 0) begin
      $display("transport_frame_segmenter test passed");
    end else begin
      $display("transport_frame_segmenter test failed");
    end
    $finish;
  end

endmodule
